// ===== design/cbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Shared codes, state encoding and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package cbc_pkg;

    typedef enum logic [1:0] {
        ACT_CTRL_WR = 2'd0,
        ACT_ROM_RD  = 2'd1,
        ACT_RAM_WR  = 2'd2,
        ACT_RAM_RD  = 2'd3
    } t_action;

    localparam logic [1:0] KIND_ROM  = 2'd0;
    localparam logic [1:0] KIND_MBC1 = 2'd1;
    localparam logic [1:0] KIND_MBC2 = 2'd2;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_stat;

endpackage

// ===== design/cbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cbc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller sequencer
// Runs the clearing pass, takes requests and hands results to the output
// register.
// ----------------------------------------------------------------------------
module cbc_ctrl
    import cbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_m_tready;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_m_tready) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;

endmodule

// ===== design/cbc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller datapath
// Bank registers, ROM address mapping, cartridge RAM and result registers.
// ----------------------------------------------------------------------------
module cbc_datapath
    import cbc_pkg::*;
#(
    parameter int RAM_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_kind,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_status,
    output logic [20:0] o_rom_address,
    output logic [7:0]  o_ram_read_data,
    output logic        o_ram_enabled
);

    localparam int          AW       = $clog2(RAM_BYTES);
    localparam logic [15:0] RamSize  = 16'(RAM_BYTES);
    localparam logic [AW-1:0] LastIdx = AW'(RAM_BYTES - 1);

    logic [1:0]    r_kind;
    logic [6:0]    r_rom_bank, n_rom_bank;
    logic [1:0]    r_ram_bank, n_ram_bank;
    logic          r_mode, n_mode;
    logic          r_en, n_en;
    logic [AW-1:0] r_clr_addr;

    logic          r_p_status;
    logic [20:0]   r_p_rom_addr;
    logic          r_p_rd;
    logic          r_p_mask;
    logic          r_o_status;
    logic [20:0]   r_o_rom_addr;
    logic [7:0]    r_o_rd;
    logic          r_o_en;

    t_action       act;
    logic          m1, m2;
    logic          bad_rom, bad_ram;
    logic [15:0]   idx_full;
    logic [AW-1:0] ram_addr;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_q;
    logic          st;
    logic [20:0]   rom_addr;

    assign act     = t_action'(i_action);
    assign m1      = (r_kind == KIND_MBC1);
    assign m2      = (r_kind == KIND_MBC2);
    assign bad_rom = i_address[15];
    assign bad_ram = |i_address[15:13];

    always_comb begin
        n_rom_bank = r_rom_bank;
        n_ram_bank = r_ram_bank;
        n_mode     = r_mode;
        n_en       = r_en;
        if (i_cmd.accept && act == ACT_CTRL_WR && !bad_rom) begin
            unique case (i_address[14:13])
                2'b00: begin
                    if (m1 || (m2 && !i_write_data[4])) begin
                        n_en = (i_write_data[3:0] == RAM_EN_KEY);
                    end
                end
                2'b01: begin
                    if (m1) begin
                        n_rom_bank[4:0] = (i_write_data[4:0] == 5'd0) ? 5'd1
                                                                      : i_write_data[4:0];
                    end else if (m2 && i_address[4]) begin
                        n_rom_bank = (i_write_data[3:0] == 4'd0) ? 7'd1
                                                                 : {3'd0, i_write_data[3:0]};
                    end
                end
                2'b10: begin
                    if (m1) begin
                        if (!r_mode) begin
                            n_rom_bank[6:5] = i_write_data[1:0];
                        end else begin
                            n_ram_bank = i_write_data[1:0];
                        end
                    end
                end
                2'b11: begin
                    if (m1) begin
                        n_mode = i_write_data[0];
                    end
                end
                default: begin
                    n_en = r_en;
                end
            endcase
        end
    end

    always_comb begin
        if (m1 || m2) begin
            idx_full = {1'b0, r_ram_bank, i_address[12:0]};
        end else begin
            idx_full = {3'd0, i_address[12:0]};
        end
        for (int k = 0; k < 3; k++) begin
            if (idx_full >= RamSize) begin
                idx_full = idx_full - RamSize;
            end
        end
        ram_addr = idx_full[AW-1:0];
    end

    always_comb begin
        st       = 1'b0;
        rom_addr = '0;
        unique case (act)
            ACT_CTRL_WR: st = bad_rom;
            ACT_ROM_RD: begin
                st = bad_rom;
                if (!bad_rom) begin
                    rom_addr = i_address[14] ? {r_rom_bank, i_address[13:0]}
                                             : {5'd0, i_address};
                end
            end
            ACT_RAM_WR, ACT_RAM_RD: st = bad_ram;
            default: st = 1'b0;
        endcase
    end

    always_comb begin
        ram_re = i_cmd.accept && act == ACT_RAM_RD && !bad_ram;
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = i_cmd.accept && act == ACT_RAM_WR && !bad_ram;
            ram_waddr = ram_addr;
            ram_wdata = m2 ? {4'd0, i_write_data[3:0]} : i_write_data;
        end
    end

    cbc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= KIND_ROM;
            r_rom_bank <= 7'd1;
            r_ram_bank <= 2'd0;
            r_mode     <= 1'b0;
            r_en       <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_kind <= i_cfg_kind;
            end
            r_rom_bank <= n_rom_bank;
            r_ram_bank <= n_ram_bank;
            r_mode     <= n_mode;
            r_en       <= n_en;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_status   <= st;
            r_p_rom_addr <= rom_addr;
            r_p_rd       <= ram_re;
            r_p_mask     <= m2;
        end
        if (i_cmd.load_out) begin
            r_o_status   <= r_p_status;
            r_o_rom_addr <= r_p_rom_addr;
            r_o_en       <= r_en;
            if (!r_p_rd) begin
                r_o_rd <= '0;
            end else if (r_p_mask) begin
                r_o_rd <= {4'd0, ram_q[3:0]};
            end else begin
                r_o_rd <= ram_q;
            end
        end
    end

    assign o_stat.clear_last = (r_clr_addr == LastIdx);
    assign o_status          = r_o_status;
    assign o_rom_address     = r_o_rom_addr;
    assign o_ram_read_data   = r_o_rd;
    assign o_ram_enabled     = r_o_en;

endmodule

// ===== design/cartridge_bank_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Bank controller for plain ROM, MBC1 and MBC2 cartridges with an internal
// banked cartridge RAM.
// ----------------------------------------------------------------------------
// After reset the block clears its cartridge RAM, one byte per cycle. During
// that pass s_axis_tready stays low, and the configuration channel is served
// as usual. After that, each request passes through the idle and execute
// states. In the idle state the request is accepted and the RAM is accessed.
// In the execute state the result is loaded into the output register together
// with the RAM's registered read data, and the block returns to accepting. No
// new request is taken until the last one has been loaded into the output
// register. The next request is accepted while a result still waits in the
// output register. The result of that next request is held back until the
// output register is free.
module cartridge_bank_controller
    import cbc_pkg::*;
#(
    parameter int RAM_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_wdata,    // controller_kind
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address, write_data
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // rom_address, ram_read_data, ram_enabled, zero pad
    output logic        m_axis_tuser    // status
);

    t_cmd        cmd;
    t_stat       stat;
    logic        status;
    logic [20:0] rom_address;
    logic [7:0]  ram_read_data;
    logic        ram_enabled;

    assign o_cfg_ready = 1'b1;

    cbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cbc_datapath #(
        .RAM_BYTES (RAM_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_kind      (i_cfg_wdata),
        .i_action        (s_axis_tuser),
        .i_address       (s_axis_tdata[15:0]),
        .i_write_data    (s_axis_tdata[23:16]),
        .o_status        (status),
        .o_rom_address   (rom_address),
        .o_ram_read_data (ram_read_data),
        .o_ram_enabled   (ram_enabled)
    );

    assign m_axis_tdata = {2'b00, ram_enabled, ram_read_data, rom_address};
    assign m_axis_tuser = status;

endmodule
